[hw/rtl/ssu_pkg.sv]
// ----------------------------------------------------------------------------
// ssu_pkg
// Shared constants of the segment slope and unit normal pipeline.
// ----------------------------------------------------------------------------
package ssu_pkg;

    // slope fraction bits (Q16.16)
    localparam int FRAC_BITS = 16;

    // the larger normalized magnitude has its top bit at this position
    localparam int NORM_MSB = 29;
    localparam int NORM_W   = NORM_MSB + 1;

    // squared length and square root pipeline
    localparam int SQ_W       = 62;
    localparam int SQRT_STEPS = 31;
    localparam int LEN_W      = 31;

    // unit component division
    localparam int UQ_W  = 15;
    localparam int NUM_W = NORM_W + 14 + 1;

    // Q1.14 one
    localparam logic [UQ_W-1:0] UNIT_Q14 = 15'd16384;

    // stages from the front register to the last direction stage
    localparam int SIDE_LAT = 4 + SQRT_STEPS + 1 + UQ_W;

    typedef logic [15:0] q14_t;

endpackage

[hw/rtl/ssu_delay.sv]
// ----------------------------------------------------------------------------
// ssu_delay
// Shift line that carries side data alongside a pipeline path.
// ----------------------------------------------------------------------------
module ssu_delay
    import ssu_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // advance the whole line together with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

[hw/rtl/ssu_div_step.sv]
// ----------------------------------------------------------------------------
// ssu_div_step
// One registered restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssu_div_step
    import ssu_pkg::*;
#(
    parameter int DW = 33,
    parameter int NW = 32,
    parameter int QW = 32
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] den_in,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] num_in,
    input  logic [QW-1:0] quo_in,
    output logic [DW-1:0] den_out,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] num_out,
    output logic [QW-1:0] quo_out
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;

    // bring down the next numerator bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_in, num_in[NW-1]};
        diff     = trial - {1'b0, den_in};
        ge       = (trial >= {1'b0, den_in});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_out <= den_in;
            rem_out <= rem_next;
            num_out <= num_in << 1;
            quo_out <= {quo_in[QW-2:0], ge};
        end
    end

endmodule

[hw/rtl/ssu_sqrt_step.sv]
// ----------------------------------------------------------------------------
// ssu_sqrt_step
// One registered digit step of the integer square root.
// ----------------------------------------------------------------------------
module ssu_sqrt_step
    import ssu_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [SQ_W-1:0] v_in,
    input  logic [SQ_W-1:0] res_in,
    output logic [SQ_W-1:0] v_out,
    output logic [SQ_W-1:0] res_out
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

    logic [SQ_W-1:0] sum;
    logic            ge;

    always_comb
    begin
        sum = res_in + BIT;
        ge  = (v_in >= sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_out   <= ge ? (v_in - sum) : v_in;
            res_out <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
        end
    end

endmodule

[hw/rtl/ssu_front.sv]
// ----------------------------------------------------------------------------
// ssu_front
// Orders the endpoints by x and forms dx, |dy| and the segment flags.
// ----------------------------------------------------------------------------
module ssu_front
    import ssu_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] ax,
    input  logic [W-1:0] ay,
    input  logic [W-1:0] bx,
    input  logic [W-1:0] by,
    output logic [W-1:0] sx_reg,
    output logic [W-1:0] sy_reg,
    output logic [W-1:0] ex_reg,
    output logic [W-1:0] ey_reg,
    output logic [W:0]   dx_reg,
    output logic [W:0]   ady_reg,
    output logic         dyneg_reg,
    output logic         vert_reg,
    output logic         degen_reg
);

    logic          swap;
    logic [W-1:0]  sx, sy, ex, ey;
    logic [W:0]    dx, dy;

    always_comb
    begin
        // equal x keeps the first endpoint as start
        swap = ($signed(ax) > $signed(bx));
        sx   = swap ? bx : ax;
        sy   = swap ? by : ay;
        ex   = swap ? ax : bx;
        ey   = swap ? ay : by;
        dx   = {ex[W-1], ex} - {sx[W-1], sx};
        dy   = {ey[W-1], ey} - {sy[W-1], sy};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg    <= sx;
            sy_reg    <= sy;
            ex_reg    <= ex;
            ey_reg    <= ey;
            dx_reg    <= dx;
            ady_reg   <= dy[W] ? (~dy + 1'b1) : dy;
            dyneg_reg <= dy[W];
            vert_reg  <= (dx == '0);
            degen_reg <= (dx == '0) && (dy == '0);
        end
    end

endmodule

[hw/rtl/segment_slope_unit_normal.sv]
// ----------------------------------------------------------------------------
// segment_slope_unit_normal
// Pipelined 2D segment setup: ordered endpoints, saturated slope, unit
// direction and normal in Q1.14.
//
//   channel  dir  fields (lowest bits first)
//   s_*      in   tdata: in_ax, in_ay, in_bx, in_by
//   m_*      out  tdata: start_x, start_y, end_x, end_y, slope, dir_x, dir_y,
//                        norm_x, norm_y; tuser: is_vertical, degenerate
//
// One request enters per cycle while the output is not stalled; the pipeline's
// depth is set by the square root (31 steps) and the unit division
// (15 steps) in series. The slope divider takes COORD_WIDTH steps in parallel.
// Reset clears only the valid bits. A stalled output freezes the whole
// pipeline; s_tready follows m_tready while the last stage holds a result.
// ----------------------------------------------------------------------------
module segment_slope_unit_normal
    import ssu_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // in_ax, in_ay, in_bx, in_by
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // start_x, start_y, end_x, end_y, slope, dir_x, dir_y, norm_x, norm_y
    output logic [((5*COORD_WIDTH+64+7)/8)*8-1:0]      m_tdata,
    // is_vertical, degenerate
    output logic [1:0]                                 m_tuser
);

    localparam int W       = COORD_WIDTH;
    localparam int AW      = W + 1;
    localparam int PW      = $clog2(AW);
    localparam int XW      = AW + NORM_W;
    localparam int CW      = 2 * W - FRAC_BITS + 1;
    localparam int SL_PAD  = SIDE_LAT - (W + 2);
    localparam int VLD_N   = SIDE_LAT + 2;
    localparam int SIDE_W  = 4 * W + 3;
    localparam int OUT_TDW = ((5 * W + 64 + 7) / 8) * 8;

    logic adv;
    logic [VLD_N-1:0] vld_reg;

    // whole pipeline moves unless the output holds an untaken result
    assign adv      = !vld_reg[VLD_N-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[VLD_N-2:0], s_tvalid};
        end
    end

    // ---------------- front: order and differences ----------------
    logic [W-1:0] sx, sy, ex, ey;
    logic [W:0]   dx, ady;
    logic         dyneg, vert, degen;

    ssu_front #(.W(W)) u_front
    (
        .clk       (clk),
        .en        (adv),
        .ax        (s_tdata[W-1:0]),
        .ay        (s_tdata[2*W-1:W]),
        .bx        (s_tdata[3*W-1:2*W]),
        .by        (s_tdata[4*W-1:3*W]),
        .sx_reg    (sx),
        .sy_reg    (sy),
        .ex_reg    (ex),
        .ey_reg    (ey),
        .dx_reg    (dx),
        .ady_reg   (ady),
        .dyneg_reg (dyneg),
        .vert_reg  (vert),
        .degen_reg (degen)
    );

    // side data waits for the direction path
    logic [SIDE_W-1:0] side_d;

    ssu_delay #(.WIDTH(SIDE_W), .DEPTH(SIDE_LAT)) u_side
    (
        .clk (clk),
        .en  (adv),
        .d   ({degen, vert, dyneg, ey, ex, sy, sx}),
        .q   (side_d)
    );

    // ---------------- slope: overflow check and long division ----------------
    logic [W+FRAC_BITS:0] n_full;
    logic                 ovf;
    logic [W:0]           sl_den_reg, sl_rem0_reg;
    logic [W-1:0]         sl_num0_reg;
    logic [2:0]           sl_flag_reg;

    always_comb
    begin
        n_full = {ady, {FRAC_BITS{1'b0}}};
        ovf    = (CW'(ady) >= (CW'(dx) << (W - FRAC_BITS)));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl_den_reg  <= dx;
            sl_rem0_reg <= AW'(n_full[W+FRAC_BITS:W]);
            sl_num0_reg <= n_full[W-1:0];
            sl_flag_reg <= {vert, dyneg, ovf};
        end
    end

    logic [W:0]   sl_den [W+1];
    logic [W:0]   sl_rem [W+1];
    logic [W-1:0] sl_num [W+1];
    logic [W-1:0] sl_quo [W+1];

    assign sl_den[0] = sl_den_reg;
    assign sl_rem[0] = sl_rem0_reg;
    assign sl_num[0] = sl_num0_reg;
    assign sl_quo[0] = '0;

    for (genvar i = 0; i < W; i++)
    begin : g_sl_div
        ssu_div_step #(.DW(AW), .NW(W), .QW(W)) u_step
        (
            .clk     (clk),
            .en      (adv),
            .den_in  (sl_den[i]),
            .rem_in  (sl_rem[i]),
            .num_in  (sl_num[i]),
            .quo_in  (sl_quo[i]),
            .den_out (sl_den[i+1]),
            .rem_out (sl_rem[i+1]),
            .num_out (sl_num[i+1]),
            .quo_out (sl_quo[i+1])
        );
    end

    logic [2:0] sl_flag_d;

    ssu_delay #(.WIDTH(3), .DEPTH(W)) u_sl_flag
    (
        .clk (clk),
        .en  (adv),
        .d   (sl_flag_reg),
        .q   (sl_flag_d)
    );

    // sign and saturation
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] slope_next, slope_reg, slope_d;
    logic [W-1:0] mag;

    always_comb
    begin
        mag = sl_quo[W];
        if (sl_flag_d[2])
        begin
            slope_next = '0;
        end
        else if (sl_flag_d[1])
        begin
            slope_next = (sl_flag_d[0] || (mag > MINNEG)) ? MINNEG : (~mag + 1'b1);
        end
        else
        begin
            slope_next = (sl_flag_d[0] || mag[W-1]) ? MAXPOS : mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slope_reg <= slope_next;
        end
    end

    ssu_delay #(.WIDTH(W), .DEPTH(SL_PAD)) u_sl_pad
    (
        .clk (clk),
        .en  (adv),
        .d   (slope_reg),
        .q   (slope_d)
    );

    // ---------------- direction: find the top bit ----------------
    logic [W:0]    mx;
    logic [PW-1:0] msb;
    logic [W:0]    na_reg, nb_reg;
    logic [PW-1:0] msb_reg;

    always_comb
    begin
        mx  = (dx > ady) ? dx : ady;
        msb = '0;
        for (int i = 0; i < AW; i++)
        begin
            if (mx[i])
            begin
                msb = PW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            na_reg  <= dx;
            nb_reg  <= ady;
            msb_reg <= msb;
        end
    end

    // normalize both magnitudes by the same shift
    logic [XW-1:0]     ext_a, ext_b, sh_a, sh_b;
    logic [NORM_W-1:0] a_reg, b_reg;

    always_comb
    begin
        ext_a = XW'(na_reg);
        ext_b = XW'(nb_reg);
        if (msb_reg >= PW'(NORM_MSB))
        begin
            sh_a = ext_a >> (msb_reg - PW'(NORM_MSB));
            sh_b = ext_b >> (msb_reg - PW'(NORM_MSB));
        end
        else
        begin
            sh_a = ext_a << (PW'(NORM_MSB) - msb_reg);
            sh_b = ext_b << (PW'(NORM_MSB) - msb_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= sh_a[NORM_W-1:0];
            b_reg <= sh_b[NORM_W-1:0];
        end
    end

    // squares, then their sum
    logic [2*NORM_W-1:0] aa_reg, bb_reg;
    logic [NORM_W-1:0]   a2_reg, b2_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [NORM_W-1:0]   a3_reg, b3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aa_reg <= a_reg * a_reg;
            bb_reg <= b_reg * b_reg;
            a2_reg <= a_reg;
            b2_reg <= b_reg;
            sq_reg <= SQ_W'(aa_reg) + SQ_W'(bb_reg);
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
        end
    end

    // ---------------- integer square root ----------------
    logic [SQ_W-1:0] sq_v   [SQRT_STEPS+1];
    logic [SQ_W-1:0] sq_res [SQRT_STEPS+1];

    assign sq_v[0]   = sq_reg;
    assign sq_res[0] = '0;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        ssu_sqrt_step #(.K(SQRT_STEPS - 1 - i)) u_step
        (
            .clk     (clk),
            .en      (adv),
            .v_in    (sq_v[i]),
            .res_in  (sq_res[i]),
            .v_out   (sq_v[i+1]),
            .res_out (sq_res[i+1])
        );
    end

    logic [2*NORM_W-1:0] ab_d;

    ssu_delay #(.WIDTH(2*NORM_W), .DEPTH(SQRT_STEPS)) u_ab
    (
        .clk (clk),
        .en  (adv),
        .d   ({b3_reg, a3_reg}),
        .q   (ab_d)
    );

    // rounded numerators for both components
    logic [LEN_W-1:0] len;
    logic [NUM_W-1:0] nx, ny;
    logic [LEN_W-1:0] u_den_reg, ux_rem0_reg, uy_rem0_reg;
    logic [UQ_W-1:0]  ux_num0_reg, uy_num0_reg;

    always_comb
    begin
        len = sq_res[SQRT_STEPS][LEN_W-1:0];
        nx  = (NUM_W'(ab_d[NORM_W-1:0]) << 14) + NUM_W'(len >> 1);
        ny  = (NUM_W'(ab_d[2*NORM_W-1:NORM_W]) << 14) + NUM_W'(len >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_den_reg   <= len;
            ux_rem0_reg <= LEN_W'(nx[NUM_W-1:UQ_W]);
            uy_rem0_reg <= LEN_W'(ny[NUM_W-1:UQ_W]);
            ux_num0_reg <= nx[UQ_W-1:0];
            uy_num0_reg <= ny[UQ_W-1:0];
        end
    end

    // ---------------- unit component dividers ----------------
    logic [LEN_W-1:0] ux_den [UQ_W+1];
    logic [LEN_W-1:0] ux_rem [UQ_W+1];
    logic [UQ_W-1:0]  ux_num [UQ_W+1];
    logic [UQ_W-1:0]  ux_quo [UQ_W+1];
    logic [LEN_W-1:0] uy_den [UQ_W+1];
    logic [LEN_W-1:0] uy_rem [UQ_W+1];
    logic [UQ_W-1:0]  uy_num [UQ_W+1];
    logic [UQ_W-1:0]  uy_quo [UQ_W+1];

    assign ux_den[0] = u_den_reg;
    assign ux_rem[0] = ux_rem0_reg;
    assign ux_num[0] = ux_num0_reg;
    assign ux_quo[0] = '0;
    assign uy_den[0] = u_den_reg;
    assign uy_rem[0] = uy_rem0_reg;
    assign uy_num[0] = uy_num0_reg;
    assign uy_quo[0] = '0;

    for (genvar i = 0; i < UQ_W; i++)
    begin : g_udiv
        ssu_div_step #(.DW(LEN_W), .NW(UQ_W), .QW(UQ_W)) u_x
        (
            .clk     (clk),
            .en      (adv),
            .den_in  (ux_den[i]),
            .rem_in  (ux_rem[i]),
            .num_in  (ux_num[i]),
            .quo_in  (ux_quo[i]),
            .den_out (ux_den[i+1]),
            .rem_out (ux_rem[i+1]),
            .num_out (ux_num[i+1]),
            .quo_out (ux_quo[i+1])
        );

        ssu_div_step #(.DW(LEN_W), .NW(UQ_W), .QW(UQ_W)) u_y
        (
            .clk     (clk),
            .en      (adv),
            .den_in  (uy_den[i]),
            .rem_in  (uy_rem[i]),
            .num_in  (uy_num[i]),
            .quo_in  (uy_quo[i]),
            .den_out (uy_den[i+1]),
            .rem_out (uy_rem[i+1]),
            .num_out (uy_num[i+1]),
            .quo_out (uy_quo[i+1])
        );
    end

    // ---------------- output register ----------------
    logic [UQ_W-1:0] ux, uy;
    q14_t            dir_x_next, dir_y_next;
    q14_t            dir_x_reg, dir_y_reg;
    logic [W-1:0]    start_x_reg, start_y_reg, end_x_reg, end_y_reg, slope_out_reg;
    logic            vert_out_reg, degen_out_reg;

    always_comb
    begin
        ux = (ux_quo[UQ_W] > UNIT_Q14) ? UNIT_Q14 : ux_quo[UQ_W];
        uy = (uy_quo[UQ_W] > UNIT_Q14) ? UNIT_Q14 : uy_quo[UQ_W];
        if (side_d[4*W+2])
        begin
            dir_x_next = '0;
            dir_y_next = '0;
        end
        else
        begin
            dir_x_next = {1'b0, ux};
            dir_y_next = side_d[4*W] ? (~{1'b0, uy} + 1'b1) : {1'b0, uy};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            start_x_reg   <= side_d[W-1:0];
            start_y_reg   <= side_d[2*W-1:W];
            end_x_reg     <= side_d[3*W-1:2*W];
            end_y_reg     <= side_d[4*W-1:3*W];
            vert_out_reg  <= side_d[4*W+1];
            degen_out_reg <= side_d[4*W+2];
            slope_out_reg <= slope_d;
            dir_x_reg     <= dir_x_next;
            dir_y_reg     <= dir_y_next;
        end
    end

    assign m_tvalid = vld_reg[VLD_N-1];
    assign m_tdata  = OUT_TDW'({(~dir_x_reg + 1'b1), dir_y_reg, dir_y_reg, dir_x_reg,
                                slope_out_reg, end_y_reg, end_x_reg,
                                start_y_reg, start_x_reg});
    assign m_tuser  = {degen_out_reg, vert_out_reg};

    // ---------------- assertions ----------------
    a_degen_vert: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && degen_out_reg |-> vert_out_reg)
        else $error("degenerate result not marked vertical");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && degen_out_reg |-> (dir_x_reg == '0) && (dir_y_reg == '0))
        else $error("degenerate result has nonzero direction");

    a_vert_slope: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && vert_out_reg |-> (slope_out_reg == '0))
        else $error("vertical result has nonzero slope");

    a_dirx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !dir_x_reg[15] && (dir_x_reg <= q14_t'(UNIT_Q14)))
        else $error("dir_x out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

endmodule
